>>> hw/rtl/afs_pkg.sv
// shared types and constants for the animation frame sequencer
`default_nettype none
package afs_pkg;

  localparam int CMD_W   = 2;
  localparam int INST_W  = 6;
  localparam int AID_W   = 2;
  localparam int FRM_W   = 16;
  localparam int ABS_W   = 18;
  localparam int LERP_W  = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int MASK_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_BLEND = 2'd1,
    CMD_SET   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch request and read the instance record
    logic upd;       // compute next record from the read data
    logic div_start; // start the shared divider
    logic div_sel;   // 0 sync divide, 1 lerp divide
    logic sync_take; // latch the sync quotient for the current frame
    logic wr;        // write the record back
    logic emit;      // build the result register
  } afs_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic need_sync;
    logic need_lerp;
  } afs_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/afs_if.sv
// valid/ready channels of the sequencer
`default_nettype none
interface afs_in_if;
  logic                      valid;
  logic                      ready;
  logic [afs_pkg::CMD_W-1:0] cmd;
  logic [afs_pkg::INST_W-1:0] instance_req;
  logic [afs_pkg::AID_W-1:0] anim_id;
  logic [afs_pkg::FRM_W-1:0] start_frame;
  logic [afs_pkg::FRM_W-1:0] blend_time;
  logic                      blend_sync;
  modport source (output valid, cmd, instance_req, anim_id, start_frame, blend_time,
                  blend_sync, input ready);
  modport sink (input valid, cmd, instance_req, anim_id, start_frame, blend_time,
                blend_sync, output ready);
endinterface

interface afs_out_if;
  logic                        valid;
  logic                        ready;
  logic [afs_pkg::INST_W-1:0]  out_instance;
  logic [afs_pkg::ABS_W-1:0]   anim_frame;
  logic [afs_pkg::ABS_W-1:0]   blend_frame;
  logic [afs_pkg::LERP_W-1:0]  lerp;
  logic                        blending;
  modport source (output valid, out_instance, anim_frame, blend_frame, lerp, blending,
                  input ready);
  modport sink (input valid, out_instance, anim_frame, blend_frame, lerp, blending,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/afs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module afs_div #(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              busy,
  output logic [W-1:0]      quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, q_r[W-1]};
    if (start) begin
      rem_nxt = '0;
      q_nxt   = num;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = W'(trial - {1'b0, d_r});
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      d_r <= den;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;
endmodule
`default_nettype wire

>>> hw/rtl/afs_ctrl.sv
// sequencing state machine
`default_nettype none
module afs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  output logic                    in_ready,
  input  wire logic               out_busy,
  input  wire afs_pkg::afs_stat_t stat,
  output afs_pkg::afs_cmd_t       cmd
);
  import afs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_SYNC  = 7'b0001000,
    S_LERP  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // record read data now registered
        if (stat.need_sync) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_SYNC;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_SYNC: begin
        if (!stat.div_busy) begin
          cmd.sync_take = 1'b1;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        cmd.wr  = 1'b1;
        state_nxt = S_LERP;
      end
      S_LERP: begin
        if (stat.need_lerp) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy && !out_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire

>>> hw/rtl/afs_dp.sv
// instance record memory, frame arithmetic and result register
`default_nettype none
module afs_dp #(
  parameter int NUM_INSTANCES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire afs_pkg::afs_cmd_t             cmd,
  output afs_pkg::afs_stat_t                 stat,
  input  wire logic [afs_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [afs_pkg::INST_W-1:0]    in_inst,
  input  wire logic [afs_pkg::AID_W-1:0]     in_aid,
  input  wire logic [afs_pkg::FRM_W-1:0]     in_sf,
  input  wire logic [afs_pkg::FRM_W-1:0]     in_bt,
  input  wire logic                          in_bs,
  input  wire logic                          cfg_we,
  input  wire logic [afs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [afs_pkg::CFG_DAT_W-1:0] cfg_dat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [afs_pkg::INST_W-1:0]         out_instance,
  output logic [afs_pkg::ABS_W-1:0]          anim_frame,
  output logic [afs_pkg::ABS_W-1:0]          blend_frame,
  output logic [afs_pkg::LERP_W-1:0]         lerp,
  output logic                               blending
);
  import afs_pkg::*;

  localparam int IW = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
  localparam int DW = FRM_W + 16 + 8; // covers both divide forms

  typedef struct packed {
    logic [AID_W-1:0] ca;
    logic [FRM_W-1:0] cf;
    logic             cp;
    logic             act;
    logic [AID_W-1:0] ta;
    logic [FRM_W-1:0] tf;
    logic             tp;
    logic             sm;
    logic [FRM_W-1:0] el;
    logic [FRM_W-1:0] du;
  } rec_t;

  localparam rec_t REC_RST = '{du: 16'd1, default: '0};

  rec_t                   mem [NUM_INSTANCES];
  logic [NUM_INSTANCES-1:0] vld_r;
  rec_t                   rd_r, rdv, nr_r, nr_nxt;
  logic [FRM_W-1:0]       len_r [4];
  logic [MASK_W-1:0]      mask_r;
  logic [CMD_W-1:0]       c_r;
  logic [INST_W-1:0]      i_r;
  logic [AID_W-1:0]       a_r;
  logic [FRM_W-1:0]       sf_r, bt_r, sq_r;
  logic                   bs_r, oor_r, seen_r;
  logic [IW-1:0]          addr;
  logic                   div_busy;
  logic [DW-1:0]          quo, dnum, dden;

  function automatic logic [FRM_W-1:0] len_of(input logic [AID_W-1:0] a,
                                              input logic [FRM_W-1:0] l0,
                                              input logic [FRM_W-1:0] l1,
                                              input logic [FRM_W-1:0] l2,
                                              input logic [FRM_W-1:0] l3);
    logic [FRM_W-1:0] l;
    case (a)
      2'd0: l = l0;
      2'd1: l = l1;
      2'd2: l = l2;
      default: l = l3;
    endcase
    return (l == '0) ? FRM_W'(1) : l;
  endfunction

  // one advance step of a frame and its half-rate phase
  function automatic logic [FRM_W:0] adv(input logic [FRM_W-1:0] f,
                                         input logic p, input logic half,
                                         input logic [FRM_W-1:0] len);
    logic [FRM_W:0] g;
    logic np;
    g  = {1'b0, f};
    np = 1'b0;
    if (!half) begin
      g = g + 1'b1;
    end else if (!p) begin
      np = 1'b1;
    end else begin
      g = g + 1'b1;
    end
    if (g >= {1'b0, len}) g = '0;
    return {np, g[FRM_W-1:0]};
  endfunction

  function automatic logic [ABS_W-1:0] absf(input logic [AID_W-1:0] a,
                                           input logic [FRM_W-1:0] f,
                                           input logic [FRM_W-1:0] l0,
                                           input logic [FRM_W-1:0] l1,
                                           input logic [FRM_W-1:0] l2);
    logic [ABS_W-1:0] s;
    s = ABS_W'(f);
    if (a > 2'd0) s = s + ABS_W'(len_of(2'd0, l0, l1, l2, l0));
    if (a > 2'd1) s = s + ABS_W'(len_of(2'd1, l0, l1, l2, l0));
    if (a > 2'd2) s = s + ABS_W'(len_of(2'd2, l0, l1, l2, l0));
    return s;
  endfunction

  // record read follows the incoming item on its accepting edge
  assign addr = cmd.load ? in_inst[IW-1:0] : i_r[IW-1:0];
  assign rdv  = seen_r ? rd_r : REC_RST;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0] <= 16'd1; len_r[1] <= 16'd1; len_r[2] <= 16'd1; len_r[3] <= 16'd1;
      mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LEN0: len_r[0] <= cfg_dat;
        REG_LEN1: len_r[1] <= cfg_dat;
        REG_LEN2: len_r[2] <= cfg_dat;
        REG_LEN3: len_r[3] <= cfg_dat;
        REG_MASK: mask_r   <= cfg_dat[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch and record read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r  <= in_cmd;
      i_r  <= in_inst;
      a_r  <= in_aid;
      sf_r <= in_sf;
      bt_r <= in_bt;
      bs_r <= in_bs;
      oor_r <= (32'(in_inst) >= NUM_INSTANCES);
    end
    rd_r   <= mem[addr];
    seen_r <= vld_r[addr];
    if (cmd.wr && !oor_r) begin
      mem[addr] <= nr_nxt;
    end
    if (cmd.upd) begin
      nr_r <= nr_nxt;
    end
    if (cmd.sync_take) begin
      sq_r <= quo[FRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr && !oor_r) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // target frame after its advance, needed before the sync divide
  logic [FRM_W:0]   tadv;
  logic [FRM_W-1:0] lt1, ls1;
  assign tadv = adv(rdv.tf, rdv.tp, mask_r[rdv.ta],
                    len_of(rdv.ta, len_r[0], len_r[1], len_r[2], len_r[3]));
  assign lt1  = len_of(rdv.ta, len_r[0], len_r[1], len_r[2], len_r[3]) - 1'b1;
  assign ls1  = len_of(rdv.ca, len_r[0], len_r[1], len_r[2], len_r[3]) - 1'b1;

  logic [2*FRM_W-1:0] prod;
  assign prod = ls1 * tadv[FRM_W-1:0];

  assign stat.need_sync = (c_r == CMD_TICK) && !oor_r && rdv.act && rdv.sm && (lt1 != '0);
  assign stat.need_lerp = !oor_r && nr_r.act && (nr_r.el != '0);
  assign stat.div_busy  = div_busy;

  always_comb begin
    logic [FRM_W:0] cadv;
    nr_nxt = rdv;
    cadv   = adv(rdv.cf, rdv.cp, mask_r[rdv.ca],
                 len_of(rdv.ca, len_r[0], len_r[1], len_r[2], len_r[3]));
    case (c_r)
      CMD_TICK: begin
        if (!rdv.act) begin
          nr_nxt.cf = cadv[FRM_W-1:0];
          nr_nxt.cp = cadv[FRM_W];
        end else begin
          nr_nxt.tf = tadv[FRM_W-1:0];
          nr_nxt.tp = tadv[FRM_W];
          if (!rdv.sm) begin
            nr_nxt.cf = cadv[FRM_W-1:0];
            nr_nxt.cp = cadv[FRM_W];
          end else begin
            nr_nxt.cf = (lt1 == '0) ? '0 : sq_r;
          end
          if (rdv.el >= rdv.du) begin
            nr_nxt.ca  = rdv.ta;
            nr_nxt.cf  = tadv[FRM_W-1:0];
            nr_nxt.cp  = tadv[FRM_W];
            nr_nxt.act = 1'b0;
            nr_nxt.ta  = '0;
            nr_nxt.tf  = '0;
            nr_nxt.tp  = 1'b0;
          end else begin
            nr_nxt.el = rdv.el + 1'b1;
          end
        end
      end
      CMD_BLEND: begin
        nr_nxt.ta  = a_r;
        nr_nxt.tf  = '0;
        nr_nxt.tp  = 1'b0;
        nr_nxt.sm  = bs_r;
        nr_nxt.du  = (bt_r == '0) ? FRM_W'(1) : bt_r;
        nr_nxt.el  = '0;
        nr_nxt.act = 1'b1;
      end
      CMD_SET: begin
        nr_nxt.ca  = a_r;
        nr_nxt.cf  = sf_r;
        nr_nxt.cp  = 1'b0;
        nr_nxt.act = 1'b0;
        nr_nxt.ta  = '0;
        nr_nxt.tf  = '0;
        nr_nxt.tp  = 1'b0;
        nr_nxt.el  = '0;
      end
      default: ;
    endcase
  end

  assign dnum = cmd.div_sel ? DW'({nr_r.el - 1'b1, 16'd0}) : DW'(prod);
  assign dden = cmd.div_sel ? DW'(nr_r.du) : DW'(lt1);

  afs_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(dnum), .den(dden), .busy(div_busy), .quo(quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_instance <= i_r;
      if (oor_r) begin
        anim_frame  <= '0;
        blend_frame <= '0;
        lerp        <= '0;
        blending    <= 1'b0;
      end else begin
        anim_frame <= absf(nr_r.ca, nr_r.cf, len_r[0], len_r[1], len_r[2]);
        blending   <= nr_r.act;
        blend_frame <= nr_r.act ? absf(nr_r.ta, nr_r.tf, len_r[0], len_r[1], len_r[2]) : '0;
        lerp <= (nr_r.act && nr_r.el != '0) ? quo[LERP_W-1:0] : '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/animation_frame_sequencer_core.sv
// top level of the animation frame sequencer
//
// channel | dir | handshake   | payload
// in      | in  | valid/ready | cmd, instance_req, anim_id, start_frame, blend_time, blend_sync
// out     | out | valid/ready | out_instance, anim_frame, blend_frame, lerp, blending
// cfg     | in  | write only  | cfg_we, cfg_index, cfg_data
//
// one item at a time, with the sync divide and the lerp divide both on the
// one shared restoring divider
// rst_n is synchronous; instance records read as reset values until first written
// a result waiting on out holds the next item in S_WAIT, before its emit step
`default_nettype none
module animation_frame_sequencer_core #(
  parameter int NUM_INSTANCES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  afs_in_if.sink                             in_ch,
  afs_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [afs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [afs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import afs_pkg::*;

  afs_cmd_t  cmd;
  afs_stat_t stat;
  logic      in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  afs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(in_ch.ready),
    .out_busy(out_ch.valid && !out_ch.ready), .stat(stat), .cmd(cmd)
  );

  afs_dp #(.NUM_INSTANCES(NUM_INSTANCES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_cmd(in_ch.cmd), .in_inst(in_ch.instance_req), .in_aid(in_ch.anim_id),
    .in_sf(in_ch.start_frame), .in_bt(in_ch.blend_time), .in_bs(in_ch.blend_sync),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_dat(cfg_data),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_instance(out_ch.out_instance), .anim_frame(out_ch.anim_frame),
    .blend_frame(out_ch.blend_frame), .lerp(out_ch.lerp), .blending(out_ch.blending)
  );
endmodule
`default_nettype wire
